// File: src/fpdl_pkg.sv
`timescale 1ns / 1ps
package fpdl_pkg;

  localparam int MAX_INPUTS = 1024;
  localparam int ADDR_W     = $clog2(MAX_INPUTS);
  localparam int LEN_W      = ADDR_W + 1;
  localparam int DATA_W     = 16;
  localparam int ACC_W      = 32;
  localparam int NUM_W      = 10;
  localparam int SHIFT_W    = 4;
  localparam int IPN_W      = 11;
  localparam int CFG_W      = 11;
  localparam int Q_DEPTH    = 4;
  localparam int Q_PTR_W    = $clog2(Q_DEPTH);
  localparam int Q_CNT_W    = Q_PTR_W + 1;

  typedef enum logic [1:0] {
    CFG_FRAC_SHIFT = 2'd0,
    CFG_INPUTS     = 2'd1,
    CFG_RELU       = 2'd2
  } cfg_idx_t;

  typedef enum logic {
    CMD_LOAD   = 1'b0,
    CMD_WEIGHT = 1'b1
  } cmd_t;

  // Settings seen by front and back; len is already clamped to 1..MAX_INPUTS.
  typedef struct packed {
    logic [SHIFT_W-1:0] frac_shift;
    logic [LEN_W-1:0]   len;
    logic               relu;
  } cfg_t;

  // One classified operation between front and back.
  typedef struct packed {
    cmd_t               cmd;
    logic [ADDR_W-1:0]  addr;
    logic [DATA_W-1:0]  data;
    logic [DATA_W-1:0]  bias;
    logic               last;
  } op_t;

endpackage

// File: src/fpdl_cmd_q.sv
`timescale 1ns / 1ps
module fpdl_cmd_q
  import fpdl_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  op_t  din,
  output logic full,
  input  logic pop,
  output op_t  dout,
  output logic empty
);

  op_t                slot_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_r, wr_nxt;
  logic [Q_PTR_W-1:0] rd_r, rd_nxt;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign full    = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign empty   = (cnt_r == '0);
  assign dout    = slot_r[rd_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_nxt  = do_push ? wr_r + 1'b1 : wr_r;
    rd_nxt  = do_pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_r] <= din;
    end
  end

endmodule

// File: src/fpdl_front.sv
`timescale 1ns / 1ps
module fpdl_front
  import fpdl_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_t              cfg,
  input  logic              accept,
  input  logic              in_command,
  input  logic [DATA_W-1:0] in_activation,
  input  logic [DATA_W-1:0] in_weight,
  input  logic [DATA_W-1:0] in_bias,
  output op_t               op
);

  logic [ADDR_W-1:0] lp_r, lp_nxt;
  logic [ADDR_W-1:0] wp_r, wp_nxt;
  logic [ADDR_W-1:0] ptr_eff;
  logic [LEN_W-1:0]  ptr_inc;
  logic              wrap;

  // Restart a pointer left beyond a shortened neuron length before use.
  always_comb begin
    if (in_command == CMD_LOAD) begin
      ptr_eff = ({1'b0, lp_r} >= cfg.len) ? '0 : lp_r;
    end else begin
      ptr_eff = ({1'b0, wp_r} >= cfg.len) ? '0 : wp_r;
    end
    ptr_inc = {1'b0, ptr_eff} + 1'b1;
    wrap    = (ptr_inc >= cfg.len);

    lp_nxt = lp_r;
    wp_nxt = wp_r;
    if (accept) begin
      if (in_command == CMD_LOAD) begin
        lp_nxt = wrap ? '0 : ptr_inc[ADDR_W-1:0];
      end else begin
        wp_nxt = wrap ? '0 : ptr_inc[ADDR_W-1:0];
      end
    end

    op.cmd  = cmd_t'(in_command);
    op.addr = ptr_eff;
    op.data = (in_command == CMD_LOAD) ? in_activation : in_weight;
    op.bias = in_bias;
    op.last = (in_command == CMD_WEIGHT) && wrap;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lp_r <= '0;
      wp_r <= '0;
    end else begin
      lp_r <= lp_nxt;
      wp_r <= wp_nxt;
    end
  end

endmodule

// File: src/fpdl_back.sv
`timescale 1ns / 1ps
module fpdl_back
  import fpdl_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_t              cfg,
  input  op_t               op,
  input  logic              op_empty,
  output logic              op_pop,
  output logic              out_empty,
  input  logic              out_pop,
  output logic [DATA_W-1:0] out_neuron_value,
  output logic [NUM_W-1:0]  out_neuron_number
);

  logic [DATA_W-1:0] act_mem [MAX_INPUTS];

  logic              s1_v_r, s1_last_r;
  logic [DATA_W-1:0] s1_act_r, s1_wt_r, s1_bias_r;
  logic              s2_v_r, s2_last_r;
  logic [ACC_W-1:0]  s2_prod_r;
  logic [DATA_W-1:0] s2_bias_r;
  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic              fin_v_r;
  logic [ACC_W-1:0]  fin_acc_r;
  logic [DATA_W-1:0] fin_bias_r;
  logic [NUM_W-1:0]  cnt_r, cnt_nxt;

  logic [DATA_W-1:0] oq_val_r [Q_DEPTH];
  logic [NUM_W-1:0]  oq_num_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] oq_wr_r, oq_wr_nxt;
  logic [Q_PTR_W-1:0] oq_rd_r, oq_rd_nxt;
  logic [Q_CNT_W-1:0] oq_cnt_r, oq_cnt_nxt;

  logic [Q_CNT_W:0]  used;
  logic [ACC_W-1:0]  shifted;
  logic [DATA_W:0]   sum;
  logic [DATA_W-1:0] result;
  logic              do_out_pop;

  // Reserve an output slot for every result still in the pipe.
  always_comb begin
    used = {1'b0, oq_cnt_r} + (Q_CNT_W+1)'(s1_v_r & s1_last_r)
         + (Q_CNT_W+1)'(s2_v_r & s2_last_r) + (Q_CNT_W+1)'(fin_v_r);
    op_pop = !op_empty && (!op.last || used < (Q_CNT_W+1)'(Q_DEPTH));
  end

  // Read the store in order with the loads so a weight sees earlier loads.
  always_ff @(posedge clk) begin
    if (op_pop && op.cmd == CMD_LOAD) begin
      act_mem[op.addr] <= op.data;
    end
    s1_act_r  <= act_mem[op.addr];
    s1_wt_r   <= op.data;
    s1_bias_r <= op.bias;
    s1_last_r <= op.last;
    s2_prod_r <= ACC_W'($signed(s1_act_r) * $signed(s1_wt_r));
    s2_bias_r <= s1_bias_r;
    s2_last_r <= s1_last_r;
    if (s2_v_r && s2_last_r) begin
      fin_acc_r  <= acc_r + s2_prod_r;
      fin_bias_r <= s2_bias_r;
    end
  end

  always_comb begin
    acc_nxt = acc_r;
    if (s2_v_r) begin
      acc_nxt = s2_last_r ? '0 : acc_r + s2_prod_r;
    end
    shifted = ACC_W'($signed(fin_acc_r) >>> cfg.frac_shift);
    sum     = {shifted[DATA_W-1], shifted[DATA_W-1:0]} + {fin_bias_r[DATA_W-1], fin_bias_r};
    if (cfg.relu && (sum[DATA_W] || sum == '0)) begin
      result = '0;
    end else begin
      result = sum[DATA_W-1:0];
    end
    cnt_nxt = fin_v_r ? cnt_r + 1'b1 : cnt_r;
  end

  // Output queue; the credit check above keeps it from overflowing.
  assign out_empty         = (oq_cnt_r == '0);
  assign out_neuron_value  = oq_val_r[oq_rd_r];
  assign out_neuron_number = oq_num_r[oq_rd_r];
  assign do_out_pop        = out_pop && !out_empty;

  always_comb begin
    oq_wr_nxt  = fin_v_r ? oq_wr_r + 1'b1 : oq_wr_r;
    oq_rd_nxt  = do_out_pop ? oq_rd_r + 1'b1 : oq_rd_r;
    oq_cnt_nxt = oq_cnt_r;
    if (fin_v_r && !do_out_pop) begin
      oq_cnt_nxt = oq_cnt_r + 1'b1;
    end else if (do_out_pop && !fin_v_r) begin
      oq_cnt_nxt = oq_cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_v_r) begin
      oq_val_r[oq_wr_r] <= result;
      oq_num_r[oq_wr_r] <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r   <= 1'b0;
      s2_v_r   <= 1'b0;
      fin_v_r  <= 1'b0;
      acc_r    <= '0;
      cnt_r    <= '0;
      oq_wr_r  <= '0;
      oq_rd_r  <= '0;
      oq_cnt_r <= '0;
    end else begin
      s1_v_r   <= op_pop && op.cmd == CMD_WEIGHT;
      s2_v_r   <= s1_v_r;
      fin_v_r  <= s2_v_r && s2_last_r;
      acc_r    <= acc_nxt;
      cnt_r    <= cnt_nxt;
      oq_wr_r  <= oq_wr_nxt;
      oq_rd_r  <= oq_rd_nxt;
      oq_cnt_r <= oq_cnt_nxt;
    end
  end

endmodule

// File: src/fixed_point_dense_layer_relu_top.sv
`timescale 1ns / 1ps
// Throughput: one item per cycle unless in_full or the credit check stalls, set
//   by the single multiply-accumulate and the one-write/one-read activation store
//   in the back end. With a neuron length of one every item finishes a neuron, and
//   the output credit check then stalls the stream even with out_pop held high.
// Path: a neuron's last weight reaches the output queue (out_empty low) through
//   the command queue, the s1 and s2 registers and the fin register.
// Reset (rst_n low, synchronous): pointers, accumulator, neuron count and queues
//   clear; settings return to shift 8, 400 inputs, ReLU on. The store is not cleared.
module fixed_point_dense_layer_relu_top
  import fpdl_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // Configuration writes
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [CFG_W-1:0]  cfg_wdata,
  // Input items
  input  logic              in_push,
  output logic              in_full,
  input  logic              in_command,
  input  logic [DATA_W-1:0] in_activation,
  input  logic [DATA_W-1:0] in_weight,
  input  logic [DATA_W-1:0] in_bias,
  // Result items
  output logic              out_empty,
  input  logic              out_pop,
  output logic [DATA_W-1:0] out_neuron_value,
  output logic [NUM_W-1:0]  out_neuron_number
);

  logic [SHIFT_W-1:0] frac_shift_r;
  logic [IPN_W-1:0]   ipn_r;
  logic               relu_r;
  cfg_t               cfg;
  logic               accept;
  op_t                front_op;
  op_t                back_op;
  logic               q_empty;
  logic               q_pop;

  // Settings registers; indexes past the list are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frac_shift_r <= SHIFT_W'(8);
      ipn_r        <= IPN_W'(400);
      relu_r       <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_FRAC_SHIFT: frac_shift_r <= cfg_wdata[SHIFT_W-1:0];
        CFG_INPUTS:     ipn_r        <= cfg_wdata[IPN_W-1:0];
        CFG_RELU:       relu_r       <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Clamp the neuron length to 1..MAX_INPUTS once, for both ends.
  always_comb begin
    cfg.frac_shift = frac_shift_r;
    cfg.relu       = relu_r;
    if (ipn_r == '0) begin
      cfg.len = LEN_W'(1);
    end else if (32'(ipn_r) > MAX_INPUTS) begin
      cfg.len = LEN_W'(MAX_INPUTS);
    end else begin
      cfg.len = LEN_W'(ipn_r);
    end
  end

  assign accept = in_push && !in_full;

  // Front: track load and weight pointers and tag each item.
  fpdl_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .accept        (accept),
    .in_command    (in_command),
    .in_activation (in_activation),
    .in_weight     (in_weight),
    .in_bias       (in_bias),
    .op            (front_op)
  );

  // Short queue decouples front from back.
  fpdl_cmd_q u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .din   (front_op),
    .full  (in_full),
    .pop   (q_pop),
    .dout  (back_op),
    .empty (q_empty)
  );

  // Back: store activations, multiply-accumulate, finish neurons.
  fpdl_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg),
    .op                (back_op),
    .op_empty          (q_empty),
    .op_pop            (q_pop),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_neuron_value  (out_neuron_value),
    .out_neuron_number (out_neuron_number)
  );

endmodule

// File: verif/fixed_point_dense_layer_relu_top_tb.sv
`timescale 1ns / 1ps
module fixed_point_dense_layer_relu_top_tb;
  import fpdl_pkg::*;

  // One input item plus the neuron result it is predicted to finish, if any.
  typedef struct {
    cmd_t              cmd;
    logic [DATA_W-1:0] activation;
    logic [DATA_W-1:0] weight;
    logic [DATA_W-1:0] bias;
    bit                finishes;
    logic [DATA_W-1:0] value;
    logic [NUM_W-1:0]  number;
  } layer_item_t;

  typedef struct {
    logic [DATA_W-1:0] value;
    logic [NUM_W-1:0]  number;
  } neuron_out_t;

  logic              clk               = 1'b0;
  logic              rst_n             = 1'b0;
  logic              cfg_we            = 1'b0;
  cfg_idx_t          cfg_index         = CFG_FRAC_SHIFT;
  logic [CFG_W-1:0]  cfg_wdata         = '0;
  logic              in_push           = 1'b0;
  logic              in_full;
  logic              in_command        = CMD_LOAD;
  logic [DATA_W-1:0] in_activation     = '0;
  logic [DATA_W-1:0] in_weight         = '0;
  logic [DATA_W-1:0] in_bias           = '0;
  logic              out_empty;
  logic              out_pop           = 1'b0;
  logic [DATA_W-1:0] out_neuron_value;
  logic [NUM_W-1:0]  out_neuron_number;

  fixed_point_dense_layer_relu_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_command        (in_command),
    .in_activation     (in_activation),
    .in_weight         (in_weight),
    .in_bias           (in_bias),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_neuron_value  (out_neuron_value),
    .out_neuron_number (out_neuron_number)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Items waiting for the driver and neuron results waiting for the monitor.
  layer_item_t layer_items_q[$];
  neuron_out_t neuron_results_q[$];
  int          items_queued   = 0;
  int          items_accepted = 0;
  int          err_cnt        = 0;

  // Shadow of the layer: activation store, both pointers, accumulator, count.
  logic signed [DATA_W-1:0] act_mem   [MAX_INPUTS];
  bit                       act_valid [MAX_INPUTS];
  int                       load_ptr   = 0;
  int                       weight_ptr = 0;
  logic [ACC_W-1:0]         acc        = '0;
  logic [NUM_W-1:0]         neuron_cnt = '0;

  // Shadow of the settings, at their reset values.
  logic [SHIFT_W-1:0] shift_cfg = 4'd8;
  logic [IPN_W-1:0]   ipn_cfg   = 11'd400;
  bit                 relu_cfg  = 1'b1;

  // Clamp the programmed length to 1..MAX_INPUTS.
  function automatic int neuron_len();
    int n;
    n = ipn_cfg;
    if (n < 1) n = 1;
    if (n > MAX_INPUTS) n = MAX_INPUTS;
    return n;
  endfunction

  // Advance the shadow layer by one item and queue it with its predicted result.
  task automatic apply_to_layer(input cmd_t cmd, input logic [DATA_W-1:0] a,
                                input logic [DATA_W-1:0] w, input logic [DATA_W-1:0] b);
    layer_item_t              it;
    int                       n;
    int                       sum;
    logic signed [ACC_W-1:0]  prod;
    logic signed [ACC_W-1:0]  shifted;
    logic signed [DATA_W-1:0] sh16;
    n             = neuron_len();
    it.cmd        = cmd;
    it.activation = a;
    it.weight     = w;
    it.bias       = b;
    it.finishes   = 1'b0;
    it.value      = '0;
    it.number     = '0;
    if (cmd == CMD_LOAD) begin
      // Restart a pointer left past a shortened length, wrap after the last slot.
      if (load_ptr >= n) load_ptr = 0;
      act_mem[load_ptr]   = a;
      act_valid[load_ptr] = 1'b1;
      load_ptr++;
      if (load_ptr >= n) load_ptr = 0;
    end else begin
      if (weight_ptr >= n) weight_ptr = 0;
      prod = act_mem[weight_ptr] * $signed(w);
      acc  = acc + prod;
      weight_ptr++;
      if (weight_ptr >= n) begin
        shifted = $signed(acc) >>> shift_cfg;
        sh16    = shifted[DATA_W-1:0];
        // ReLU looks at the untruncated sum of shifted value and bias.
        sum         = int'(sh16) + int'($signed(b));
        it.finishes = 1'b1;
        it.value    = (relu_cfg && sum <= 0) ? '0 : sum[DATA_W-1:0];
        neuron_cnt  = neuron_cnt + 1'b1;
        it.number   = neuron_cnt;
        weight_ptr  = 0;
        acc         = '0;
      end
    end
    layer_items_q.push_back(it);
    items_queued++;
  endtask

  // Mostly random words, with extremes and small magnitudes mixed in.
  function automatic logic [DATA_W-1:0] rand_word();
    case ($urandom_range(0, 11))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'hFFFF;
      3:       return 16'h0000;
      4:       return 16'($urandom_range(0, 255));
      default: return 16'($urandom);
    endcase
  endfunction

  // Pick a random item; turn a weight into a load if its activation was never stored.
  task automatic add_random_item(input int load_pct);
    cmd_t cmd;
    int   n;
    int   k;
    n   = neuron_len();
    cmd = ($urandom_range(0, 99) < load_pct) ? CMD_LOAD : CMD_WEIGHT;
    k   = (weight_ptr >= n) ? 0 : weight_ptr;
    if (cmd == CMD_WEIGHT && !act_valid[k]) cmd = CMD_LOAD;
    apply_to_layer(cmd, rand_word(), rand_word(), rand_word());
  endtask

  // Idle lengths: mostly none or short, a few long; none at all in a burst.
  function automatic int pick_gap(input bit burst);
    int r;
    if (burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(11, 40);
  endfunction

  // Write one register and mirror it in the shadow settings.
  task automatic write_reg(input cfg_idx_t idx, input int val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[CFG_W-1:0];
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      CFG_FRAC_SHIFT: shift_cfg = val[SHIFT_W-1:0];
      CFG_INPUTS:     ipn_cfg   = val[IPN_W-1:0];
      CFG_RELU:       relu_cfg  = val[0];
      default:        ;
    endcase
  endtask

  // Hold until every queued item is taken and every result is back, then let
  // the pipeline empty of items that finish no neuron.
  task automatic drain_layer();
    while (items_accepted != items_queued || neuron_results_q.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Driver: present the next pending item, hold it while full, idle at random.
  layer_item_t cur_item;
  int          push_gap   = 0;
  bit          push_burst = 1'b0;

  always @(posedge clk) begin : drive_items
    if (!rst_n) begin
      in_push <= 1'b0;
    end else begin
      if (in_push && !in_full) begin
        if (cur_item.finishes)
          neuron_results_q.push_back(neuron_out_t'{cur_item.value, cur_item.number});
        items_accepted++;
      end
      if (!in_push || !in_full) begin
        if (push_gap > 0) begin
          push_gap--;
          in_push <= 1'b0;
        end else if (layer_items_q.size() != 0) begin
          cur_item       = layer_items_q.pop_front();
          in_command    <= cur_item.cmd;
          in_activation <= cur_item.activation;
          in_weight     <= cur_item.weight;
          in_bias       <= cur_item.bias;
          in_push       <= 1'b1;
          if ($urandom_range(0, 63) == 0) push_burst = !push_burst;
          push_gap = pick_gap(push_burst);
        end else begin
          in_push <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each popped result against the oldest prediction.
  int pop_stall = 0;
  bit pop_burst = 1'b0;

  always @(posedge clk) begin : check_results
    neuron_out_t want;
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        if (neuron_results_q.size() == 0) begin
          err_cnt++;
          $display("%0t unexpected result: expected none, got value %h number %0d",
                   $time, out_neuron_value, out_neuron_number);
        end else begin
          want = neuron_results_q.pop_front();
          if (out_neuron_value !== want.value) begin
            err_cnt++;
            $display("%0t neuron_value mismatch: expected %h, got %h",
                     $time, want.value, out_neuron_value);
          end
          if (out_neuron_number !== want.number) begin
            err_cnt++;
            $display("%0t neuron_number mismatch: expected %0d, got %0d",
                     $time, want.number, out_neuron_number);
          end
        end
      end
      if (pop_stall > 0) begin
        pop_stall--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
        if ($urandom_range(0, 3) == 0) pop_stall = pick_gap(pop_burst);
      end
      if ($urandom_range(0, 255) == 0) pop_burst = !pop_burst;
    end
  end

  // Stimulus: directed corner cases, random phases, an oversized length.
  initial begin : stimulus
    int  phase_len;
    int  load_pct;
    int  r;
    bit  wrote;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Short neurons, no shift: accumulator wrap, then the largest products.
    write_reg(CFG_FRAC_SHIFT, 0);
    write_reg(CFG_INPUTS, 4);
    write_reg(CFG_RELU, 1);
    repeat (4) apply_to_layer(CMD_LOAD, 16'h8000, 16'h0000, 16'h0000);
    repeat (4) apply_to_layer(CMD_WEIGHT, 16'h0000, 16'h8000, 16'h0000);
    apply_to_layer(CMD_LOAD, 16'h7FFF, 16'h0000, 16'h0000);
    apply_to_layer(CMD_LOAD, 16'hFFFF, 16'h0000, 16'h0000);
    apply_to_layer(CMD_LOAD, 16'h0001, 16'h0000, 16'h0000);
    apply_to_layer(CMD_LOAD, 16'h0000, 16'h0000, 16'h0000);
    apply_to_layer(CMD_WEIGHT, 16'h0000, 16'h7FFF, 16'h0000);
    apply_to_layer(CMD_WEIGHT, 16'h0000, 16'h7FFF, 16'h0000);
    apply_to_layer(CMD_WEIGHT, 16'h0000, 16'h8000, 16'h0000);
    apply_to_layer(CMD_WEIGHT, 16'hFFFF, 16'hFFFF, 16'h7FFF);
    // Interleave streams; the load wraps to the first slot mid-neuron.
    apply_to_layer(CMD_WEIGHT, 16'h0000, 16'h7FFF, 16'h0000);
    apply_to_layer(CMD_LOAD, 16'h8000, 16'h0000, 16'h0000);
    apply_to_layer(CMD_WEIGHT, 16'h0000, 16'h8001, 16'h0000);
    drain_layer();

    // Shrink below the weight pointer so it restarts; ReLU off, full shift.
    write_reg(CFG_INPUTS, 2);
    write_reg(CFG_RELU, 0);
    write_reg(CFG_FRAC_SHIFT, 15);
    apply_to_layer(CMD_WEIGHT, 16'h0000, 16'h8000, 16'h0000);
    apply_to_layer(CMD_WEIGHT, 16'h0000, 16'h8000, 16'h8000);
    drain_layer();

    // Length zero acts as one; the bias sum overflows 16 bits under ReLU.
    write_reg(CFG_INPUTS, 0);
    write_reg(CFG_RELU, 1);
    apply_to_layer(CMD_WEIGHT, 16'h0000, 16'h8001, 16'h7FFF);
    apply_to_layer(CMD_WEIGHT, 16'h0000, 16'h0000, 16'h8000);
    apply_to_layer(CMD_WEIGHT, 16'h0000, 16'h7FFF, 16'h0000);
    drain_layer();
    write_reg(CFG_RELU, 0);
    apply_to_layer(CMD_WEIGHT, 16'h0000, 16'h8000, 16'h8000);

    // Random phases: new settings at each idle point, mostly weight-heavy streams.
    while (items_queued < 1780) begin
      drain_layer();
      wrote = 1'b0;
      if ($urandom_range(0, 1)) begin
        write_reg(CFG_FRAC_SHIFT, ($urandom_range(0, 3) == 0) ?
                  ($urandom_range(0, 1) ? 15 : 0) : $urandom_range(0, 15));
        wrote = 1'b1;
      end
      if ($urandom_range(0, 1)) begin
        write_reg(CFG_RELU, $urandom_range(0, 1));
        wrote = 1'b1;
      end
      if ($urandom_range(0, 1) || !wrote) begin
        r = $urandom_range(0, 99);
        if (r < 20)      write_reg(CFG_INPUTS, $urandom_range(0, 1));
        else if (r < 70) write_reg(CFG_INPUTS, $urandom_range(2, 8));
        else if (r < 95) write_reg(CFG_INPUTS, $urandom_range(9, 40));
        else             write_reg(CFG_INPUTS, $urandom_range(41, 200));
      end
      phase_len = $urandom_range(20, 150);
      load_pct  = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 90) : 25;
      repeat (phase_len) add_random_item(load_pct);
    end

    // Oversized length clamps to the full store: bring both pointers to the
    // first slot with a length of one, run well past a short neuron without
    // finishing it, then shorten the length so one more weight finishes it.
    drain_layer();
    write_reg(CFG_INPUTS, 1);
    apply_to_layer(CMD_LOAD, rand_word(), rand_word(), rand_word());
    apply_to_layer(CMD_WEIGHT, rand_word(), rand_word(), rand_word());
    drain_layer();
    write_reg(CFG_INPUTS, 2047);
    write_reg(CFG_FRAC_SHIFT, $urandom_range(0, 15));
    write_reg(CFG_RELU, $urandom_range(0, 1));
    repeat (64) apply_to_layer(CMD_LOAD, rand_word(), rand_word(), rand_word());
    repeat (64) apply_to_layer(CMD_WEIGHT, rand_word(), rand_word(), rand_word());
    drain_layer();
    write_reg(CFG_INPUTS, 65);
    apply_to_layer(CMD_LOAD, rand_word(), rand_word(), rand_word());
    apply_to_layer(CMD_WEIGHT, rand_word(), rand_word(), rand_word());

    drain_layer();
    repeat (20) @(posedge clk);
    if (err_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin : watchdog
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// File: filelist.f
src/fpdl_pkg.sv
src/fpdl_cmd_q.sv
src/fpdl_front.sv
src/fpdl_back.sv
src/fixed_point_dense_layer_relu_top.sv
verif/fixed_point_dense_layer_relu_top_tb.sv
